>>> rtl/core/bsp_pkg.sv
// Shared types, constants and saturation helpers for the cubic B-spline
// point evaluator. No dependencies; every other file imports this package.
`default_nettype none

package bsp_pkg;

	// Default store depths, used as top-level parameter defaults.
	localparam int BSP_MAX_POINTS = 64;
	localparam int BSP_MAX_KNOTS  = 128;

	// Spline degree and order (knot span of one basis function).
	localparam int BSP_DEG   = 3;
	localparam int BSP_ORDER = 4;

	// Basis value 1.0 in Q1.30.
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	// Command codes carried on the slave tuser.
	localparam logic [1:0] CMD_KNOT  = 2'd0;
	localparam logic [1:0] CMD_POINT = 2'd1;
	localparam logic [1:0] CMD_EVAL  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_NUM_CONTROL = 1'b0;
	localparam logic REG_NUM_KNOTS   = 1'b1;

	// Configuration reset values.
	localparam logic [6:0] RST_NUM_CONTROL = 7'd4;
	localparam logic [7:0] RST_NUM_KNOTS   = 8'd8;

	// Evaluation sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRD,
		ST_FETCH,
		ST_KRD,
		ST_KWAIT,
		ST_BINIT,
		ST_RMUL,
		ST_RDIV,
		ST_RWAIT,
		ST_WMUL,
		ST_WACC,
		ST_XDIV,
		ST_XWAIT,
		ST_YDIV,
		ST_YWAIT,
		ST_DONE
	} bsp_state_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic               load;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic               degen;
	} bsp_res_t;

	// Signed 32-bit saturation of a quotient given as magnitude and sign.
	function automatic logic signed [31:0] sat_s32(input logic [63:0] mag, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) begin
				r = 32'sh8000_0000;
			end else begin
				r = 32'(~mag[31:0] + 32'd1);
			end
		end else begin
			if (mag > 64'h0000_0000_7FFF_FFFF) begin
				r = 32'sh7FFF_FFFF;
			end else begin
				r = mag[31:0];
			end
		end
		return r;
	endfunction

	// Unsigned 32-bit saturation of a positive quotient.
	function automatic logic [31:0] sat_u32(input logic [63:0] mag);
		logic [31:0] r;
		r = (|mag[63:32]) ? 32'hFFFF_FFFF : mag[31:0];
		return r;
	endfunction

	// Signed 32-bit saturation of a 33-bit sum.
	function automatic logic signed [31:0] sat_s33(input logic signed [32:0] s);
		logic signed [31:0] r;
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	// 64-bit add that clamps to plus or minus (2^63 - 1).
	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0]        s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (!s[64] && s[63]) begin
			r = 64'sh7FFF_FFFF_FFFF_FFFF;
		end else if (s[64] && (!s[63] || (s[62:0] == 63'd0))) begin
			r = 64'sh8000_0000_0000_0001;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bsp_store.sv
// Knot and control point memories of the spline evaluator: one write port
// and one registered read port each. Depends on bsp_pkg.
`default_nettype none

module bsp_store import bsp_pkg::*; #(
	parameter int MAX_POINTS = BSP_MAX_POINTS,
	parameter int MAX_KNOTS  = BSP_MAX_KNOTS
) (
	input  wire logic                         clk,
	input  wire logic                         knot_we,
	input  wire logic [$clog2(MAX_KNOTS)-1:0]  knot_waddr,
	input  wire logic [31:0]                  knot_wdata,
	input  wire logic [$clog2(MAX_KNOTS)-1:0]  knot_raddr,
	output logic      [31:0]                  knot_rdata,
	input  wire logic                         pt_we,
	input  wire logic [$clog2(MAX_POINTS)-1:0] pt_waddr,
	input  wire logic [31:0]                  pt_wx,
	input  wire logic [31:0]                  pt_wy,
	input  wire logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
	output logic      [31:0]                  pt_rx,
	output logic      [31:0]                  pt_ry
);

	logic [31:0] knot_mem [MAX_KNOTS];
	logic [63:0] pt_mem [MAX_POINTS];
	logic [31:0] knot_rdata_q;
	logic [63:0] pt_rdata_q;

	// Raw knot memory.
	always_ff @(posedge clk) begin
		if (knot_we) begin
			knot_mem[knot_waddr] <= knot_wdata;
		end
		knot_rdata_q <= knot_mem[knot_raddr];
	end

	// Control point memory, y in the upper half of each word.
	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= {pt_wy, pt_wx};
		end
		pt_rdata_q <= pt_mem[pt_raddr];
	end

	assign knot_rdata = knot_rdata_q;
	assign pt_rx      = pt_rdata_q[31:0];
	assign pt_ry      = pt_rdata_q[63:32];

endmodule

`default_nettype wire

>>> rtl/core/bsp_div.sv
// Shared radix-2 signed divider, one quotient bit per cycle, truncating
// toward zero. Returns magnitude and sign. Depends on bsp_pkg.
`default_nettype none

module bsp_div import bsp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [64:0] num,
	input  wire logic signed [64:0] den,
	output logic                    done,
	output logic        [63:0]      q_mag,
	output logic                    q_neg
);

	localparam int DIV_BITS = 64;
	localparam int CNT_W    = $clog2(DIV_BITS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      rem_q;
	logic [63:0]      quo_q;
	logic [63:0]      dvs_q;
	logic             neg_q;

	logic [64:0] num_abs;
	logic [64:0] den_abs;
	logic [64:0] rem_sh;
	logic [64:0] rem_diff;
	logic        fits;

	// Operand magnitudes and one restoring step.
	always_comb begin
		num_abs  = num[64] ? 65'(-num) : num;
		den_abs  = den[64] ? 65'(-den) : den;
		rem_sh   = {rem_q, quo_q[63]};
		fits     = rem_sh >= {1'b0, dvs_q};
		rem_diff = rem_sh - {1'b0, dvs_q};
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_abs[63:0];
			dvs_q <= den_abs[63:0];
			neg_q <= num[64] ^ den[64];
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[63:0] : rem_sh[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done  = done_q;
	assign q_mag = quo_q;
	assign q_neg = neg_q;

endmodule

`default_nettype wire

>>> rtl/core/bsp_eval.sv
// Evaluation sequencer: walks the control points, normalizes knots on the
// fly, runs the Cox-de Boor recursion and the weighted sums over the
// shared divider. Depends on bsp_pkg and bsp_div.
`default_nettype none

module bsp_eval import bsp_pkg::*; #(
	parameter int MAX_POINTS = BSP_MAX_POINTS,
	parameter int MAX_KNOTS  = BSP_MAX_KNOTS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [16:0]                   k_in,
	input  wire logic [6:0]                    num_control,
	input  wire logic [7:0]                    num_knots,
	output logic                               idle,
	output logic      [$clog2(MAX_KNOTS)-1:0]  knot_raddr,
	input  wire logic [31:0]                   knot_rdata,
	output logic      [$clog2(MAX_POINTS)-1:0] pt_raddr,
	input  wire logic [31:0]                   pt_rx,
	input  wire logic [31:0]                   pt_ry,
	input  wire logic                          out_free,
	output bsp_res_t                           res
);

	localparam int KAW = $clog2(MAX_KNOTS);
	localparam int PAW = $clog2(MAX_POINTS);
	localparam int NCW = $clog2(MAX_POINTS + 1);
	localparam int NKW = $clog2(MAX_KNOTS + 1);

	bsp_state_t state_q, state_d;

	logic [16:0]        k_q;
	logic [NCW-1:0]     nc_q;
	logic [NKW-1:0]     nk_q;
	logic [31:0]        d_q;
	logic [31:0]        tk_q [BSP_ORDER+1];
	logic [NCW-1:0]     i_q;
	logic signed [31:0] cx_q, cy_q;
	logic signed [31:0] b_q [BSP_ORDER];
	logic [1:0]         m_q, j_q;
	logic               side_q;
	logic signed [31:0] left_q;
	logic signed [64:0] prod_q;
	logic signed [32:0] den_q;
	logic signed [63:0] mx_q, my_q;
	logic signed [63:0] sx_q, sy_q, sb_q;
	logic signed [31:0] px_q, py_q;

	logic [NCW-1:0]     nc_clamp;
	logic [NKW-1:0]     nk_clamp;
	logic               more_pts;
	logic [2:0]         ja, jm, jm1;
	logic signed [32:0] rec_num, rec_den;
	logic signed [31:0] rec_bas;
	logic signed [64:0] rec_prod;
	logic               rec_skip;
	logic               last_j;
	logic               term_fire;
	logic signed [31:0] term_val;
	logic               div_start, div_done, div_neg;
	logic signed [64:0] div_num, div_den;
	logic [63:0]        div_mag;

	// Clamped counts and loop condition.
	always_comb begin
		nc_clamp = (32'(num_control) > MAX_POINTS) ? NCW'(MAX_POINTS) : NCW'(num_control);
		nk_clamp = (32'(num_knots) > MAX_KNOTS) ? NKW'(MAX_KNOTS) : NKW'(num_knots);
		more_pts = (32'(i_q) < 32'(nc_q)) &&
			((32'(i_q) + 32'(BSP_ORDER)) < 32'(nk_q));
	end

	// Memory read addresses: the divisor knot at start, then the window top.
	always_comb begin
		if (state_q == ST_IDLE) begin
			knot_raddr = KAW'(32'(nk_clamp) - 32'd2);
		end else begin
			knot_raddr = KAW'(32'(i_q) + 32'(BSP_ORDER));
		end
		pt_raddr = PAW'(i_q);
	end

	// Operands of one recursion term from the knot window.
	always_comb begin
		ja  = {1'b0, j_q};
		jm  = {1'b0, j_q} + {1'b0, m_q};
		jm1 = jm + 3'd1;
		if (!side_q) begin
			rec_num = $signed({16'b0, k_q}) - $signed({1'b0, tk_q[ja]});
			rec_bas = b_q[j_q];
			rec_den = $signed({1'b0, tk_q[jm]}) - $signed({1'b0, tk_q[ja]});
		end else begin
			rec_num = $signed({1'b0, tk_q[jm1]}) - $signed({16'b0, k_q});
			rec_bas = b_q[j_q + 2'd1];
			rec_den = $signed({1'b0, tk_q[jm1]}) - $signed({1'b0, tk_q[ja + 3'd1]});
		end
		rec_prod = rec_num * rec_bas;
		rec_skip = (rec_den == 33'sd0) || (rec_bas == 32'sd0);
		last_j   = (jm == 3'(BSP_DEG));
	end

	// Term result: zero when skipped, otherwise the saturated quotient.
	always_comb begin
		term_fire = ((state_q == ST_RMUL) && rec_skip) || ((state_q == ST_RWAIT) && div_done);
		term_val  = (state_q == ST_RWAIT) ? sat_s32(div_mag, div_neg) : 32'sd0;
	end

	// Divider operand selection.
	always_comb begin
		div_start = 1'b0;
		div_num   = {prod_q};
		div_den   = {{32{den_q[32]}}, den_q};
		case (state_q)
			ST_KRD: begin
				div_start = (d_q != 32'd0);
				div_num   = {17'b0, knot_rdata, 16'b0};
				div_den   = {33'b0, d_q};
			end
			ST_RDIV: begin
				div_start = 1'b1;
			end
			ST_XDIV: begin
				div_start = 1'b1;
				div_num   = {sx_q[63], sx_q};
				div_den   = {sb_q[63], sb_q};
			end
			ST_YDIV: begin
				div_start = 1'b1;
				div_num   = {sy_q[63], sy_q};
				div_den   = {sb_q[63], sb_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	bsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.q_mag  (div_mag),
		.q_neg  (div_neg)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs.
	always_comb begin
		state_d   = state_q;
		res.load  = 1'b0;
		res.degen = (sb_q == 64'sd0);
		res.px    = res.degen ? 32'sd0 : px_q;
		res.py    = res.degen ? 32'sd0 : py_q;
		idle      = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DRD;
				end
			end
			ST_DRD: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				if (more_pts) begin
					state_d = ST_KRD;
				end else if (sb_q == 64'sd0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_XDIV;
				end
			end
			ST_KRD: begin
				state_d = (d_q == 32'd0) ? ST_BINIT : ST_KWAIT;
			end
			ST_KWAIT: begin
				if (div_done) begin
					state_d = ST_BINIT;
				end
			end
			ST_BINIT: begin
				state_d = ST_RMUL;
			end
			ST_RMUL: begin
				if (!rec_skip) begin
					state_d = ST_RDIV;
				end else if (side_q && last_j && (m_q == 2'(BSP_DEG))) begin
					state_d = ST_WMUL;
				end
			end
			ST_RDIV: begin
				state_d = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (div_done) begin
					state_d = (side_q && last_j && (m_q == 2'(BSP_DEG))) ? ST_WMUL : ST_RMUL;
				end
			end
			ST_WMUL: begin
				state_d = ST_WACC;
			end
			ST_WACC: begin
				state_d = ST_FETCH;
			end
			ST_XDIV: begin
				state_d = ST_XWAIT;
			end
			ST_XWAIT: begin
				if (div_done) begin
					state_d = ST_YDIV;
				end
			end
			ST_YDIV: begin
				state_d = ST_YWAIT;
			end
			ST_YWAIT: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					k_q  <= k_in;
					nc_q <= nc_clamp;
					nk_q <= nk_clamp;
					i_q  <= '0;
					sx_q <= '0;
					sy_q <= '0;
					sb_q <= '0;
					for (int n = 0; n <= BSP_ORDER; n++) begin
						tk_q[n] <= '0;
					end
				end
			end
			ST_DRD: begin
				d_q <= (32'(nk_q) >= 32'd2) ? knot_rdata : 32'd0;
			end
			ST_KRD: begin
				cx_q <= $signed(pt_rx);
				cy_q <= $signed(pt_ry);
				if (d_q == 32'd0) begin
					tk_q[BSP_ORDER] <= 32'd0;
				end
			end
			ST_KWAIT: begin
				if (div_done) begin
					tk_q[BSP_ORDER] <= sat_u32(div_mag);
				end
			end
			ST_BINIT: begin
				for (int n = 0; n < BSP_ORDER; n++) begin
					b_q[n] <= (({15'b0, k_q} >= tk_q[n]) && ({15'b0, k_q} <= tk_q[n+1])) ?
						ONE_Q30 : 32'sd0;
				end
				m_q    <= 2'd1;
				j_q    <= 2'd0;
				side_q <= 1'b0;
			end
			ST_RMUL: begin
				if (!rec_skip) begin
					prod_q <= rec_prod;
					den_q  <= rec_den;
				end
			end
			ST_WMUL: begin
				mx_q <= b_q[0] * cx_q;
				my_q <= b_q[0] * cy_q;
			end
			ST_WACC: begin
				sx_q <= sat_add64(sx_q, mx_q);
				sy_q <= sat_add64(sy_q, my_q);
				sb_q <= sb_q + {{32{b_q[0][31]}}, b_q[0]};
				i_q  <= i_q + NCW'(1);
				for (int n = 0; n < BSP_ORDER; n++) begin
					tk_q[n] <= tk_q[n+1];
				end
			end
			ST_XWAIT: begin
				if (div_done) begin
					px_q <= sat_s32(div_mag, div_neg);
				end
			end
			ST_YWAIT: begin
				if (div_done) begin
					py_q <= sat_s32(div_mag, div_neg);
				end
			end
			default: begin
			end
		endcase

		// Combine left and right terms and step through the triangle.
		if (term_fire) begin
			if (!side_q) begin
				left_q <= term_val;
				side_q <= 1'b1;
			end else begin
				b_q[j_q] <= sat_s33({left_q[31], left_q} + {term_val[31], term_val});
				side_q   <= 1'b0;
				if (last_j) begin
					m_q <= m_q + 2'd1;
					j_q <= 2'd0;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/cubic_bspline_point_eval.sv
// Cubic B-spline point evaluator. An evaluate word runs, per control point
// used, a division for its knot (when the divisor knot is nonzero) and up
// to 12 recursion divisions, then, unless the weight sum is zero, one
// division each for x and y, all on one shared bit-serial divider.
// One item is worked on at a time; a result waits in the output register.
// Reset is asynchronous, active low; it clears control state and sets
// num_control to 4 and num_knots to 8. Memories are undefined until written.
`default_nettype none

module cubic_bspline_point_eval import bsp_pkg::*; #(
	parameter int MAX_POINTS = BSP_MAX_POINTS,
	parameter int MAX_KNOTS  = BSP_MAX_KNOTS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// index[6:0], knot_raw[38:7], coord_x[70:39], coord_y[102:71], param_k[119:103]
	input  wire logic [119:0] s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]   s_tuser,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// point_x[31:0], point_y[63:32]
	output logic      [63:0]  m_tdata,
	// degenerate[0]
	output logic      [0:0]   m_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire logic         cfg_we,
	input  wire logic         cfg_idx,
	input  wire logic [7:0]   cfg_wdata
);

	localparam int KAW = $clog2(MAX_KNOTS);
	localparam int PAW = $clog2(MAX_POINTS);

	logic [1:0]  cmd;
	logic [6:0]  index;
	logic [31:0] knot_raw;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [16:0] param_k;
	logic        accept;
	logic        knot_we, pt_we, eval_start;
	logic        eval_idle;
	logic [6:0]  num_control_q;
	logic [7:0]  num_knots_q;
	logic [KAW-1:0] knot_raddr;
	logic [PAW-1:0] pt_raddr;
	logic [31:0] knot_rdata, pt_rx, pt_ry;
	logic        out_free;
	bsp_res_t    res;
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic        m_tuser_q;

	// Word fields and command decode.
	always_comb begin
		cmd        = s_tuser;
		index      = s_tdata[6:0];
		knot_raw   = s_tdata[38:7];
		coord_x    = s_tdata[70:39];
		coord_y    = s_tdata[102:71];
		param_k    = s_tdata[119:103];
		s_tready   = eval_idle;
		accept     = s_tvalid && s_tready;
		knot_we    = accept && (cmd == CMD_KNOT) && (32'(index) < MAX_KNOTS);
		pt_we      = accept && (cmd == CMD_POINT) && (32'(index) < MAX_POINTS);
		eval_start = accept && (cmd == CMD_EVAL);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_control_q <= RST_NUM_CONTROL;
			num_knots_q   <= RST_NUM_KNOTS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NUM_CONTROL: num_control_q <= cfg_wdata[6:0];
				REG_NUM_KNOTS:   num_knots_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	bsp_store #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_KNOTS  (MAX_KNOTS)
	) u_store (
		.clk        (clk),
		.knot_we    (knot_we),
		.knot_waddr (KAW'(index)),
		.knot_wdata (knot_raw),
		.knot_raddr (knot_raddr),
		.knot_rdata (knot_rdata),
		.pt_we      (pt_we),
		.pt_waddr   (PAW'(index)),
		.pt_wx      (coord_x),
		.pt_wy      (coord_y),
		.pt_raddr   (pt_raddr),
		.pt_rx      (pt_rx),
		.pt_ry      (pt_ry)
	);

	bsp_eval #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_KNOTS  (MAX_KNOTS)
	) u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (eval_start),
		.k_in        (param_k),
		.num_control (num_control_q),
		.num_knots   (num_knots_q),
		.idle        (eval_idle),
		.knot_raddr  (knot_raddr),
		.knot_rdata  (knot_rdata),
		.pt_raddr    (pt_raddr),
		.pt_rx       (pt_rx),
		.pt_ry       (pt_ry),
		.out_free    (out_free),
		.res         (res)
	);

	// Output register: free when empty or being drained this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			m_tdata_q <= {res.py, res.px};
			m_tuser_q <= res.degen;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

`default_nettype wire

>>> rtl/core/bsp_chk.sv
// Port-level checks for the spline evaluator, bound to the top level.
// Depends on bsp_pkg and cubic_bspline_point_eval.
`default_nettype none

module bsp_chk import bsp_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic [1:0]   s_tuser,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [63:0]  m_tdata,
	input wire logic [0:0]   m_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// An evaluate word occupies the block on the next cycle.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_EVAL) |=> !s_tready)
		else $error("evaluate word did not start the sequencer");

	// Write words complete at once.
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != CMD_EVAL) |=> s_tready)
		else $error("write word stalled the input");

	// A degenerate point is forced to zero.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 64'd0))
		else $error("degenerate point not zero");

endmodule

bind cubic_bspline_point_eval bsp_chk u_bsp_chk (.*);

`default_nettype wire

>>> sim/cubic_bspline_point_eval_tb.sv
// Self-checking testbench for the cubic B-spline point evaluator.
// Depends on bsp_pkg and cubic_bspline_point_eval; keeps its own spline predictor.
`timescale 1ns / 100ps

module cubic_bspline_point_eval_tb;
	import bsp_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               degen;
	} curve_point_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [119:0] s_tdata = '0;
	logic [1:0]   s_tuser = CMD_KNOT;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_idx = REG_NUM_CONTROL;
	logic [7:0]   cfg_wdata = '0;

	// Predictor copy of the stores and registers.
	logic [31:0]        knot_mem [BSP_MAX_KNOTS];
	logic [31:0]        ctrl_x_mem [BSP_MAX_POINTS];
	logic [31:0]        ctrl_y_mem [BSP_MAX_POINTS];
	longint             norm_knot [BSP_MAX_KNOTS];
	logic [6:0]         num_control = RST_NUM_CONTROL;
	logic [7:0]         num_knots = RST_NUM_KNOTS;

	curve_point_t point_q[$];
	int  errors = 0;
	int  words_sent = 0;
	int  points_seen = 0;
	int  hold_left = 0;
	int  rx_wait = 0;
	bit  no_idle = 1'b0;

	cubic_bspline_point_eval i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -128'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic longint add_clamp64(longint a, longint b);
		longint top;
		top = 64'sh7FFF_FFFF_FFFF_FFFF;
		if (b > 0 && a > top - b) return top;
		if (b < 0 && a < -top - b) return -top;
		return a + b;
	endfunction

	// One Cox-de Boor term; a zero knot difference gives zero.
	function automatic logic signed [31:0] blend_term(longint num, logic signed [31:0] basis,
			longint den);
		logic signed [127:0] n, b, d;
		if (den == 0) return 0;
		n = num;
		b = basis;
		d = den;
		return clamp32((n * b) / d);
	endfunction

	// Cubic basis value for control point i at parameter k, Q1.30.
	function automatic logic signed [31:0] cubic_weight(int i, longint k);
		logic signed [31:0] b [4];
		longint t0, t1, tm, tm1;
		logic signed [127:0] s;
		for (int j = 0; j < 4; j++)
			b[j] = (k >= norm_knot[i+j] && k <= norm_knot[i+j+1]) ? ONE_Q30 : 32'sd0;
		for (int m = 1; m <= 3; m++) begin
			for (int j = 0; j + m <= 3; j++) begin
				t0 = norm_knot[i+j];
				t1 = norm_knot[i+j+1];
				tm = norm_knot[i+j+m];
				tm1 = norm_knot[i+j+m+1];
				s = 128'(blend_term(k - t0, b[j], tm - t0)) +
					128'(blend_term(tm1 - k, b[j+1], tm1 - t1));
				b[j] = clamp32(s);
			end
		end
		return b[0];
	endfunction

	// Expected curve point for an evaluate word.
	function automatic curve_point_t curve_point(logic [16:0] k_in);
		int nc, nk;
		logic [31:0] d;
		logic [63:0] q;
		longint k, sx, sy, sb, bw;
		curve_point_t r;
		nc = (num_control > BSP_MAX_POINTS) ? BSP_MAX_POINTS : num_control;
		nk = (num_knots > BSP_MAX_KNOTS) ? BSP_MAX_KNOTS : num_knots;
		d = (nk >= 2) ? knot_mem[nk-2] : 32'd0;
		for (int j = 0; j < BSP_MAX_KNOTS; j++) begin
			q = 0;
			if (j >= 4 && d != 0) begin
				q = {knot_mem[j], 16'h0} / {32'h0, d};
				if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
			end
			norm_knot[j] = q;
		end
		k = k_in;
		sx = 0; sy = 0; sb = 0;
		for (int i = 0; i < nc && i + 4 < nk; i++) begin
			bw = cubic_weight(i, k);
			sx = add_clamp64(sx, bw * longint'($signed(ctrl_x_mem[i])));
			sy = add_clamp64(sy, bw * longint'($signed(ctrl_y_mem[i])));
			sb += bw;
		end
		r.degen = (sb == 0);
		r.x = r.degen ? 32'sd0 : clamp32(128'(sx / sb));
		r.y = r.degen ? 32'sd0 : clamp32(128'(sy / sb));
		return r;
	endfunction

	// Sends one word; on acceptance updates the predictor. Starts and ends at a falling edge.
	task automatic send_word(logic [1:0] cmd, logic [6:0] idx, logic [31:0] knot,
			logic [31:0] cx, logic [31:0] cy, logic [16:0] k);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {k, cy, cx, knot, idx};
		s_tuser = cmd;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		case (cmd)
			CMD_KNOT: knot_mem[idx] = knot;
			CMD_POINT: if (idx < BSP_MAX_POINTS) begin
				ctrl_x_mem[idx] = cx;
				ctrl_y_mem[idx] = cy;
			end
			CMD_EVAL: point_q.push_back(curve_point(k));
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic eval_at(logic [16:0] k);
		send_word(CMD_EVAL, $urandom, $urandom, $urandom, $urandom, k);
	endtask

	// Drains the block, then writes one register while it is idle.
	task automatic set_reg(logic idx, logic [7:0] value);
		s_tvalid = 1'b0;
		wait (point_q.size() == 0);
		repeat (12) @(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_NUM_CONTROL) num_control = value[6:0];
		else num_knots = value;
	endtask

	// Sets the counts and loads a knot vector, non-decreasing from index 4 on, and random control points.
	task automatic load_curve(int nc, int nk, int step_max);
		logic [31:0] acc;
		set_reg(REG_NUM_CONTROL, nc);
		set_reg(REG_NUM_KNOTS, nk);
		acc = $urandom_range(0, step_max);
		for (int j = 0; j < nk && j < BSP_MAX_KNOTS; j++) begin
			if (j >= 4 && $urandom_range(0, 4) != 0) acc += $urandom_range(1, step_max);
			send_word(CMD_KNOT, j, (j < 4) ? 32'($urandom) : acc, $urandom, $urandom, 0);
		end
		for (int i = 0; i < nc && i < BSP_MAX_POINTS; i++)
			send_word(CMD_POINT, i, $urandom, $urandom_range(0, 3) == 0 ? $urandom :
				$urandom_range(0, 1 << 24), $urandom_range(0, 3) == 0 ? $urandom :
				$urandom_range(0, 1 << 24), 0);
	endtask

	// Every store entry gets written so no evaluation reads an unwritten one.
	task automatic test_fill_stores();
		for (int j = 0; j < BSP_MAX_KNOTS; j++)
			send_word(CMD_KNOT, j, j * 32'h1000, $urandom, $urandom, 0);
		for (int i = 0; i < BSP_MAX_POINTS; i++)
			send_word(CMD_POINT, i, $urandom, $urandom, $urandom, 0);
	endtask

	// Edge values of the parameter, coordinates and knots; also a bad command and an out-of-range point index.
	task automatic test_directed_cases();
		eval_at(17'd0);
		eval_at(17'd65536);
		eval_at(17'h1FFFF);
		eval_at(17'd12288);
		send_word(2'd3, 7'd5, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 17'd100);
		send_word(CMD_POINT, 7'd100, $urandom, 32'h1234, 32'h5678, 0);
		send_word(CMD_POINT, 7'd0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_word(CMD_POINT, 7'd1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		eval_at(17'd30000);
		// Knot far above a small divisor saturates its normalized value.
		send_word(CMD_KNOT, 7'd6, 32'h0000_0001, 0, 0, 0);
		send_word(CMD_KNOT, 7'd7, 32'hFFFF_FFFF, 0, 0, 0);
		eval_at(17'd40000);
		eval_at(17'd65535);
		// Zero divisor: every knot collapses to zero.
		send_word(CMD_KNOT, 7'd6, 32'h0, 0, 0, 0);
		eval_at(17'd0);
		eval_at(17'd777);
	endtask

	// Counts at zero, too few knots, and beyond the store sizes.
	task automatic test_count_extremes();
		set_reg(REG_NUM_CONTROL, 8'd0);
		eval_at(17'd1000);
		load_curve(1, 5, 20000);
		eval_at(17'd30000);
		eval_at(17'd0);
		set_reg(REG_NUM_KNOTS, 8'd0);
		eval_at(17'd0);
		set_reg(REG_NUM_KNOTS, 8'd1);
		eval_at(17'd500);
		load_curve(6, 7, 30000);
		eval_at(17'd20000);
		load_curve(64, 128, 1 << 20);
		eval_at($urandom_range(0, 65536));
		set_reg(REG_NUM_CONTROL, 8'd127);
		set_reg(REG_NUM_KNOTS, 8'd255);
		eval_at($urandom_range(0, 65536));
	endtask

	// Receiver holds off while evaluate words back up at the input; once all results are out, four more go with no gaps.
	task automatic test_backpressure();
		load_curve(2, 6, 20000);
		hold_left = 3000;
		repeat (4) eval_at($urandom_range(0, 65536));
		s_tvalid = 1'b0;
		wait (point_q.size() == 0);
		@(negedge clk);
		no_idle = 1'b1;
		repeat (4) eval_at($urandom_range(0, 65536));
		no_idle = 1'b0;
	endtask

	// Mostly well-formed curves with random content, mixed with noise words.
	task automatic test_random_curves();
		int nc, nk;
		while (words_sent < 700 || points_seen < 40) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(3, 10))
					send_word($urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom_range(0, 3) == 0 ? 17'($urandom) : 17'd0);
			end else begin
				nc = $urandom_range(1, 5);
				nk = nc + 4 + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0);
				if ($urandom_range(0, 9) == 0) nk = $urandom_range(2, nc + 4);
				no_idle = ($urandom_range(0, 5) == 0);
				load_curve(nc, nk, $urandom_range(0, 1) ? 20000 : 1 << 24);
				repeat ($urandom_range(2, 4))
					eval_at($urandom_range(0, 7) == 0 ? 17'($urandom) :
						17'($urandom_range(0, 65536)));
				no_idle = 1'b0;
			end
		end
	endtask

	// Result side: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (rx_wait > 0) begin
			m_tready = 1'b0;
			rx_wait--;
		end else begin
			m_tready = 1'b1;
			if ($urandom_range(0, 3) == 0) rx_wait = pick_gap();
		end
	end

	// Compare each accepted word against the oldest expected point.
	always @(posedge clk) begin
		curve_point_t e;
		if (arst_n && m_tvalid && m_tready) begin
			points_seen++;
			if (point_q.size() == 0) begin
				errors++;
				$display("%t unexpected word x=%h y=%h degen=%b", $time,
					m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
			end else begin
				e = point_q.pop_front();
				if (m_tdata[31:0] !== e.x) begin
					errors++;
					$display("%t point_x expected %h actual %h", $time, e.x, m_tdata[31:0]);
				end
				if (m_tdata[63:32] !== e.y) begin
					errors++;
					$display("%t point_y expected %h actual %h", $time, e.y, m_tdata[63:32]);
				end
				if (m_tuser[0] !== e.degen) begin
					errors++;
					$display("%t degenerate expected %b actual %b", $time, e.degen,
						m_tuser[0]);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill_stores();
		test_directed_cases();
		test_count_extremes();
		test_backpressure();
		test_random_curves();
		s_tvalid = 1'b0;
		wait (point_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("cubic_bspline_point_eval regression: pass");
		end else begin
			$display("cubic_bspline_point_eval regression: fail");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#60_000_000;
		$display("cubic_bspline_point_eval regression: fail");
		$finish;
	end

endmodule
